// File: hw/rtl/lphtp_pkg.sv
// Shared types, constants and helpers for the linear-probe hash table pair.
package lphtp_pkg;

  // TableSize must be a power of two (home slot is a mask of the key).
  localparam int TableSize = 16;
  localparam int IdxW      = $clog2(TableSize);
  localparam int CntW      = $clog2(TableSize + 1);
  localparam int KeyW      = 16;
  localparam int ValueW    = 34;
  localparam int ProbeW    = 5;
  localparam int ProbeMax  = 31;

  localparam logic [ValueW-1:0] MinValue = 34'd1000000000;

  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_e;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic              done;
    logic              ok;
    logic [ProbeW-1:0] probes;
  } probe_res_t;

  function automatic idx_t home_of(input logic [KeyW-1:0] key);
    logic [KeyW-1:0] m;
    m = key % KeyW'(TableSize);
    return m[IdxW-1:0];
  endfunction

  function automatic idx_t next_slot(input idx_t p);
    if (p == idx_t'(TableSize - 1)) begin
      return '0;
    end
    return p + idx_t'(1);
  endfunction

  function automatic logic [ProbeW-1:0] sat_probes(input logic [CntW-1:0] n);
    logic [31:0] w;
    w = 32'(n);
    if (w > 32'(ProbeMax)) begin
      return ProbeW'(ProbeMax);
    end
    return w[ProbeW-1:0];
  endfunction

endpackage

// File: hw/rtl/lphtp_table.sv
// One open-addressed table: slot memory, valid bits and the probe sequencer.
module lphtp_table import lphtp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              replace_i,
  input  logic              start_i,
  input  logic              op_i,
  input  logic [KeyW-1:0]   key_i,
  input  logic [ValueW-1:0] value_i,
  output probe_res_t        res_o
);

  entry_t mem [TableSize];
  entry_t rdata_q;

  logic [TableSize-1:0] vld_q;
  logic                 act_q, mv_q, done_q, ok_q, foreign_q;
  logic [ProbeW-1:0]    probes_q;
  logic [CntW-1:0]      cnt_q;
  idx_t                 eptr_q, home_q;
  op_e                  op_q;
  entry_t               new_q, disp_q;

  idx_t   rd_addr, wr_addr;
  entry_t wr_data;
  logic   wr_en, fin, fin_ok, mv_d, cap_disp;
  logic   slot_vld, hit, last;

  assign rd_addr  = start_i ? home_of(key_i) : next_slot(eptr_q);
  assign slot_vld = vld_q[eptr_q];
  assign hit      = slot_vld && (rdata_q.key == new_q.key) && (rdata_q.value == new_q.value);
  assign last     = (cnt_q == CntW'(TableSize));

  always_comb begin
    fin      = 1'b0;
    fin_ok   = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = eptr_q;
    wr_data  = new_q;
    mv_d     = 1'b0;
    cap_disp = 1'b0;
    if (mv_q) begin
      // second write of a displacement: new entry takes its home slot
      wr_en   = 1'b1;
      wr_addr = home_q;
    end else if (act_q) begin
      if (op_q == OP_SEARCH) begin
        fin    = !slot_vld || hit || last;
        fin_ok = hit;
      end else if (!slot_vld) begin
        fin    = 1'b1;
        fin_ok = 1'b1;
        wr_en  = 1'b1;
        if (replace_i && (cnt_q != CntW'(1)) && foreign_q) begin
          wr_data = disp_q;
          mv_d    = 1'b1;
        end
      end else if (last) begin
        fin = 1'b1;
      end else if (replace_i && (cnt_q == CntW'(1))) begin
        cap_disp = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      act_q     <= 1'b0;
      mv_q      <= 1'b0;
      done_q    <= 1'b0;
      ok_q      <= 1'b0;
      probes_q  <= '0;
      cnt_q     <= '0;
      eptr_q    <= '0;
      home_q    <= '0;
      op_q      <= OP_INSERT;
      new_q     <= '0;
      disp_q    <= '0;
      foreign_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (start_i) begin
        act_q     <= 1'b1;
        mv_q      <= 1'b0;
        done_q    <= 1'b0;
        cnt_q     <= CntW'(1);
        eptr_q    <= home_of(key_i);
        home_q    <= home_of(key_i);
        op_q      <= op_e'(op_i);
        new_q     <= '{key: key_i, value: value_i};
        foreign_q <= 1'b0;
      end else begin
        if (fin) begin
          act_q    <= 1'b0;
          ok_q     <= fin_ok;
          probes_q <= sat_probes(cnt_q);
          mv_q     <= mv_d;
          done_q   <= !mv_d;
        end else if (act_q) begin
          cnt_q  <= cnt_q + CntW'(1);
          eptr_q <= next_slot(eptr_q);
        end
        if (mv_q) begin
          mv_q   <= 1'b0;
          done_q <= 1'b1;
        end
        if (cap_disp) begin
          disp_q    <= rdata_q;
          foreign_q <= (home_of(rdata_q.key) != home_q);
        end
      end
    end
  end

  assign res_o = '{done: done_q, ok: ok_q, probes: probes_q};

endmodule

// File: hw/rtl/linear_probe_hash_table_pair_top.sv
// Top level of the linear-probe hash table pair (plain and replacement tables).
//
// Command channel: a request (operation, key, value) is taken at a rising edge
// with start_i high and busy_o low. Insert (operation 0) stores the pair in
// both tables; search (operation 1) looks for the pair in both.
// Result channel: result_valid_o is high for exactly one cycle with status,
// ok flags and probe counts; the receiver cannot stall it.
// Timing: a value below 1000000000 is rejected and its result shows in the
// cycle after acceptance with busy_o staying low. Otherwise both tables probe
// in parallel, one slot read per cycle from each table's registered slot
// memory; the result follows once both tables have finished, after an extra
// write when the replacement table writes back a displaced entry. One request
// is in flight at a time; busy_o drops in the cycle the result is shown, so
// the next request may start there.
// Reset clears all valid bits at once: both tables are empty and the block
// takes requests in the first cycle after reset.
module linear_probe_hash_table_pair_top import lphtp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              operation_i,
  input  logic [KeyW-1:0]   key_i,
  input  logic [ValueW-1:0] value_i,
  output logic              result_valid_o,
  output logic              status_o,
  output logic              plain_ok_o,
  output logic [ProbeW-1:0] plain_probes_o,
  output logic              swap_ok_o,
  output logic [ProbeW-1:0] swap_probes_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e     state_q, state_d;
  probe_res_t plain_res, swap_res;

  logic accept, reject, go, both_done;
  logic res_vld_q, status_q, plain_ok_q, swap_ok_q;
  logic [ProbeW-1:0] plain_probes_q, swap_probes_q;

  assign busy_o    = (state_q != ST_IDLE);
  assign accept    = start_i && !busy_o;
  assign reject    = (value_i < MinValue);
  assign go        = accept && !reject;
  assign both_done = (state_q == ST_RUN) && plain_res.done && swap_res.done;

  lphtp_table u_plain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .replace_i (1'b0),
    .start_i   (go),
    .op_i      (operation_i),
    .key_i     (key_i),
    .value_i   (value_i),
    .res_o     (plain_res)
  );

  lphtp_table u_swap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .replace_i (1'b1),
    .start_i   (go),
    .op_i      (operation_i),
    .key_i     (key_i),
    .value_i   (value_i),
    .res_o     (swap_res)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (go) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (both_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      res_vld_q      <= 1'b0;
      status_q       <= 1'b0;
      plain_ok_q     <= 1'b0;
      plain_probes_q <= '0;
      swap_ok_q      <= 1'b0;
      swap_probes_q  <= '0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= (accept && reject) || both_done;
      if (accept && reject) begin
        status_q       <= 1'b1;
        plain_ok_q     <= 1'b0;
        plain_probes_q <= '0;
        swap_ok_q      <= 1'b0;
        swap_probes_q  <= '0;
      end else if (both_done) begin
        status_q       <= 1'b0;
        plain_ok_q     <= plain_res.ok;
        plain_probes_q <= plain_res.probes;
        swap_ok_q      <= swap_res.ok;
        swap_probes_q  <= swap_res.probes;
      end
    end
  end

  assign result_valid_o = res_vld_q;
  assign status_o       = status_q;
  assign plain_ok_o     = plain_ok_q;
  assign plain_probes_o = plain_probes_q;
  assign swap_ok_o      = swap_ok_q;
  assign swap_probes_o  = swap_probes_q;

endmodule

// File: hw/rtl/lphtp_check.sv
// Port-level checker for the hash table pair, bound to the top level.
module lphtp_check import lphtp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              operation_i,
  input logic [KeyW-1:0]   key_i,
  input logic [ValueW-1:0] value_i,
  input logic              result_valid_o,
  input logic              status_o,
  input logic              plain_ok_o,
  input logic [ProbeW-1:0] plain_probes_o,
  input logic              swap_ok_o,
  input logic [ProbeW-1:0] swap_probes_o
);

  // a rejected beat answers in the next cycle with status set
  a_reject_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (value_i < MinValue) |=> result_valid_o && status_o)
    else $error("rejected beat not answered in next cycle");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> !plain_ok_o && !swap_ok_o &&
      (plain_probes_o == '0) && (swap_probes_o == '0))
    else $error("rejected result carries nonzero fields");

  a_go_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (value_i >= MinValue) |=> busy_o)
    else $error("accepted beat did not raise busy");

  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !status_o |-> (plain_probes_o != '0) && (swap_probes_o != '0) &&
      (32'(plain_probes_o) <= TableSize) && (32'(swap_probes_o) <= TableSize))
    else $error("probe count out of range");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !status_o |-> $past(busy_o))
    else $error("table result without a busy cycle before it");

endmodule

bind linear_probe_hash_table_pair_top lphtp_check u_check (.*);
